// File: hw/rtl/ptagc_pkg.sv
`default_nettype none
package ptagc_pkg;

  // field widths
  localparam int SampleW = 16;
  localparam int MagW    = 17;
  localparam int GainW   = 24;
  localparam int PeakW   = 16;
  localparam int MgainW  = 19;
  localparam int CfgAddrW = 2;
  localparam int OutDataW = 56;

  // register indexes
  localparam logic [CfgAddrW-1:0] REG_AUTO_EN = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_INVERT  = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_MGAIN   = 2'd2;

  // reset values
  localparam logic [PeakW-1:0]  PEAK_RST  = 16'd328;    // 0.01 in Q1.15
  localparam logic [GainW-1:0]  GAIN_RST  = 24'd16384;  // 1.0 in Q10.14
  localparam logic [MgainW-1:0] MGAIN_RST = 19'd16384;

  // arithmetic constants
  localparam logic [15:0] DECAY_Q16  = 16'd65470;     // 0.999
  localparam logic [PeakW-1:0] PEAK_FLOOR = 16'd32;   // just under 0.001
  localparam logic [28:0] TARGET_NUM = 29'd429496730; // 0.8 * 2^29
  localparam logic [15:0] KEEP_Q16   = 16'd62259;     // 0.95
  localparam logic [11:0] TAKE_Q16   = 12'd3277;      // 0.05
  localparam logic [14:0] OUT_SCALE  = 15'd32000;
  localparam int DivSteps = 24;                       // quotient < 2^24
  localparam int DivCntW  = 5;
  localparam int ProdClampW = 30;                     // above this, output saturates

  typedef struct packed {
    logic load;       // take input sample
    logic manual;     // gain <= manual_gain
    logic decay;      // product of peak and decay factor
    logic peak_upd;   // peak <= max(decayed, magnitude); divider init
    logic div_step;
    logic mix_mul;
    logic mix_add;
    logic app_mul1;
    logic app_mul2;
    logic finish;     // load output register
  } ptagc_cmd_t;

  typedef struct packed {
    logic auto_en;
    logic peak_above; // updated peak above floor
    logic div_last;
  } ptagc_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/ptagc_dp.sv
`default_nettype none
module ptagc_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire ptagc_pkg::ptagc_cmd_t              cmd,
  output ptagc_pkg::ptagc_sts_t                   sts,
  input  wire logic                               cfg_we,
  input  wire logic [ptagc_pkg::CfgAddrW-1:0]     cfg_addr,
  input  wire logic [ptagc_pkg::MgainW-1:0]       cfg_wdata,
  input  wire logic [ptagc_pkg::SampleW-1:0]      sample,
  output logic      [ptagc_pkg::OutDataW-1:0]     out_data
);

  logic                            auto_en_r;
  logic                            invert_r;
  logic [ptagc_pkg::MgainW-1:0]    mgain_r;
  logic [ptagc_pkg::PeakW-1:0]     peak_r;
  logic [ptagc_pkg::GainW-1:0]     gain_r;
  logic [ptagc_pkg::MagW-1:0]      mag_r;
  logic                            neg_r;
  logic [31:0]                     dprod_r;
  logic [15:0]                     rem_r;
  logic [ptagc_pkg::DivSteps-1:0]  num_sh_r;
  logic [ptagc_pkg::GainW-1:0]     quo_r;
  logic [ptagc_pkg::DivCntW-1:0]   cnt_r;
  logic [39:0]                     mixa_r;
  logic [35:0]                     mixb_r;
  logic [ptagc_pkg::ProdClampW-1:0] p1_r;
  logic [44:0]                     p2_r;
  logic [ptagc_pkg::OutDataW-1:0]  out_r;

  logic [ptagc_pkg::MagW-1:0]      mag_in;
  logic [ptagc_pkg::PeakW-1:0]     peak_dec;
  logic [ptagc_pkg::PeakW-1:0]     peak_max;
  logic [16:0]                     rem_sh;
  logic                            fits;
  logic [40:0]                     mix_sum;
  logic [40:0]                     p1_full;
  logic [15:0]                     scaled;
  logic                            neg_out;
  logic [15:0]                     pcm;

  assign mag_in = sample[ptagc_pkg::SampleW-1] ?
                  (17'h10000 - {1'b0, sample}) : {1'b0, sample};

  assign peak_dec = dprod_r[31:16];
  assign peak_max = ({1'b0, peak_dec} < mag_r) ? mag_r[ptagc_pkg::PeakW-1:0] : peak_dec;

  assign rem_sh = {rem_r, num_sh_r[ptagc_pkg::DivSteps-1]};
  assign fits   = rem_sh >= {1'b0, peak_r};

  assign mix_sum = {1'b0, mixa_r} + {5'd0, mixb_r} + 41'd32768;
  assign p1_full = mag_r * gain_r;

  assign scaled  = p2_r[44:29];
  assign neg_out = neg_r ^ invert_r;
  always_comb begin
    if (neg_out) begin
      pcm = (scaled > 16'd32768) ? 16'h8000 : (16'd0 - scaled);
    end else begin
      pcm = (scaled > 16'd32767) ? 16'h7fff : scaled;
    end
  end

  assign sts.auto_en    = auto_en_r;
  assign sts.peak_above = peak_max > ptagc_pkg::PEAK_FLOOR;
  assign sts.div_last   = cnt_r == ptagc_pkg::DivCntW'(ptagc_pkg::DivSteps - 1);
  assign out_data       = out_r;

  // config and tracked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_en_r <= 1'b1;
      invert_r  <= 1'b0;
      mgain_r   <= ptagc_pkg::MGAIN_RST;
      peak_r    <= ptagc_pkg::PEAK_RST;
      gain_r    <= ptagc_pkg::GAIN_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ptagc_pkg::REG_AUTO_EN: auto_en_r <= cfg_wdata[0];
          ptagc_pkg::REG_INVERT:  invert_r  <= cfg_wdata[0];
          ptagc_pkg::REG_MGAIN:   mgain_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.peak_upd) begin
        peak_r <= peak_max;
      end
      if (cmd.manual) begin
        gain_r <= {5'd0, mgain_r};
      end else if (cmd.mix_add) begin
        gain_r <= mix_sum[39:16];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= mag_in;
      neg_r <= sample[ptagc_pkg::SampleW-1];
    end
    if (cmd.decay) begin
      dprod_r <= peak_r * ptagc_pkg::DECAY_Q16;
    end
    if (cmd.peak_upd) begin
      // top quotient bits are zero since the divisor exceeds 32
      rem_r    <= {11'd0, ptagc_pkg::TARGET_NUM[28:24]};
      num_sh_r <= ptagc_pkg::TARGET_NUM[23:0];
      quo_r    <= '0;
      cnt_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r    <= fits ? 16'(rem_sh - {1'b0, peak_r}) : rem_sh[15:0];
      num_sh_r <= {num_sh_r[ptagc_pkg::DivSteps-2:0], 1'b0};
      quo_r    <= {quo_r[ptagc_pkg::GainW-2:0], fits};
      cnt_r    <= cnt_r + 1'b1;
    end
    if (cmd.mix_mul) begin
      mixa_r <= gain_r * ptagc_pkg::KEEP_Q16;
      mixb_r <= quo_r * ptagc_pkg::TAKE_Q16;
    end
    if (cmd.app_mul1) begin
      // large products saturate anyway; clamp before scaling
      p1_r <= (|p1_full[40:ptagc_pkg::ProdClampW]) ? '1 :
              p1_full[ptagc_pkg::ProdClampW-1:0];
    end
    if (cmd.app_mul2) begin
      p2_r <= p1_r * ptagc_pkg::OUT_SCALE;
    end
    if (cmd.finish) begin
      out_r <= {peak_r, gain_r, pcm};
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ptagc_ctrl.sv
`default_nettype none
module ptagc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire ptagc_pkg::ptagc_sts_t  sts,
  output ptagc_pkg::ptagc_cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECAY  = 9'b000000010,
    S_PEAK   = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_MIXMUL = 9'b000010000,
    S_MIXADD = 9'b000100000,
    S_MUL1   = 9'b001000000,
    S_MUL2   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load   = 1'b1;
          cmd.manual = !sts.auto_en;
          state_nxt  = sts.auto_en ? S_DECAY : S_MUL1;
        end
      end
      S_DECAY: begin
        cmd.decay = 1'b1;
        state_nxt = S_PEAK;
      end
      S_PEAK: begin
        cmd.peak_upd = 1'b1;
        state_nxt    = sts.peak_above ? S_DIV : S_MUL1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MIXMUL;
        end
      end
      S_MIXMUL: begin
        cmd.mix_mul = 1'b1;
        state_nxt   = S_MIXADD;
      end
      S_MIXADD: begin
        cmd.mix_add = 1'b1;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.app_mul1 = 1'b1;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        cmd.app_mul2 = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/peak_tracking_agc.sv
`default_nettype none
// Peak-tracking automatic gain control for a signed Q1.15 sample stream.
// Each input transfer carries one sample and yields exactly one output
// transfer holding the gained pcm sample (scaled by 32000/32768, saturated
// to 16 bits), the Q10.14 gain applied and the Q1.15 peak after the sample.
// In automatic mode the peak decays by 0.999 per sample and jumps to the
// sample magnitude; above a floor of 0.001 the target gain 0.8/peak is formed
// by a radix-2 restoring divider and blended in as 0.95 old + 0.05 target.
// In manual mode the manual_gain register is used directly. The divider
// loop makes automatic mode the longest path from an input transfer to
// the output transfer of its result; the path is shorter when the peak
// stays under the floor and shortest in manual mode. A finished result is
// held in the output register while the output stalls. Input is taken
// only while the controller is idle, but a finished result held in the
// output register does not block the next input transfer. Config writes
// (cfg_we, cfg_addr, cfg_wdata) are taken any cycle and are meant to land
// while the block is idle: 0 auto_gain_enable, 1 invert_polarity,
// 2 manual_gain; index 3 is ignored.
module peak_tracking_agc (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ptagc_pkg::SampleW-1:0]      in_tdata,   // [15:0] in_sample
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [15:0] out_pcm, [39:16] gain_now, [55:40] peak_now
  output logic      [ptagc_pkg::OutDataW-1:0]     out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [ptagc_pkg::CfgAddrW-1:0]     cfg_addr,
  input  wire logic [ptagc_pkg::MgainW-1:0]       cfg_wdata
);

  ptagc_pkg::ptagc_cmd_t cmd;
  ptagc_pkg::ptagc_sts_t sts;

  // sequencer: one-hot FSM, owns both handshakes
  ptagc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: config registers, peak/gain state, divider, multipliers
  ptagc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sample    (in_tdata),
    .out_data  (out_tdata)
  );

endmodule
`default_nettype wire
